### rtl/core/vad_pkg.sv
// ============================================================================
// vad_pkg: shared types, constants and arctangent table for the angle core
// Holds the beat structs, fixed-point sizing and the per-iteration
// arctangent constants used by the CORDIC cells.
// ============================================================================
package vad_pkg;

  // Sizing of the datapath
  localparam int COORD_WIDTH   = 16;  // bits of each coordinate used (<= FIELD_W)
  localparam int FRAC_BITS     = 7;   // fraction bits of the output angle
  localparam int CORDIC_STAGES = 16;  // number of vectoring iterations (8..32)

  localparam int FIELD_W   = 16;                 // width of the coordinate fields
  localparam int ANGLE_W   = 16;                 // width of the angle field
  localparam int PRESCALE  = 24;                 // magnitude pre-scale shift
  localparam int ANG_BITS  = 24;                 // fraction bits of the accumulator
  localparam int DATA_W    = COORD_WIDTH + PRESCALE + 3;  // x/y with growth and sign
  localparam int Z_W       = 32;                 // angle accumulator, signed
  localparam int STAGE_W   = $clog2(CORDIC_STAGES);
  localparam int TAB_IDX_W = 5;                  // table holds 32 entries
  localparam int A_W       = FRAC_BITS + 7;      // first quadrant angle, <= 90 deg
  localparam int RES_W     = FRAC_BITS + 10;     // full angle before masking
  localparam int ANG_SHIFT = ANG_BITS - FRAC_BITS;

  localparam logic [Z_W-1:0]   Z_MAX     = Z_W'(64'd90 << ANG_BITS);
  localparam logic [Z_W-1:0]   Z_ROUND   = Z_W'(64'd1 << (ANG_SHIFT - 1));
  localparam logic [RES_W-1:0] FULL_TURN = RES_W'(64'd360 << FRAC_BITS);
  localparam logic [RES_W-1:0] HALF_TURN = RES_W'(64'd180 << FRAC_BITS);
  localparam logic [RES_W-1:0] QTR_TURN  = RES_W'(64'd90 << FRAC_BITS);
  localparam logic [RES_W-1:0] TQTR_TURN = RES_W'(64'd270 << FRAC_BITS);

  // Input and result beats
  typedef struct packed {
    logic signed [FIELD_W-1:0] x_coord;
    logic signed [FIELD_W-1:0] y_coord;
  } vad_in_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle_deg;
    logic               undefined_flag;
  } vad_out_t;

  // Quadrant information riding alongside the CORDIC data
  typedef struct packed {
    logic valid;
    logic x_neg;
    logic x_zero;
    logic y_neg;
    logic y_zero;
  } vad_ctl_t;

  // CORDIC working set handed from cell to cell
  typedef struct packed {
    logic signed [DATA_W-1:0] cx;
    logic signed [DATA_W-1:0] cy;
    logic signed [Z_W-1:0]    z;
  } vad_cord_t;

  // atan(2^-i) in degrees * 2^24, rounded to nearest
  function automatic logic [Z_W-1:0] atan_entry(logic [TAB_IDX_W-1:0] idx);
    logic [Z_W-1:0] val;
    case (idx)
      5'd0:    val = 32'd754974720;
      5'd1:    val = 32'd445687602;
      5'd2:    val = 32'd235489088;
      5'd3:    val = 32'd119537938;
      5'd4:    val = 32'd60000934;
      5'd5:    val = 32'd30029717;
      5'd6:    val = 32'd15018523;
      5'd7:    val = 32'd7509720;
      5'd8:    val = 32'd3754917;
      5'd9:    val = 32'd1877466;
      5'd10:   val = 32'd938734;
      5'd11:   val = 32'd469367;
      5'd12:   val = 32'd234684;
      5'd13:   val = 32'd117342;
      5'd14:   val = 32'd58671;
      5'd15:   val = 32'd29335;
      5'd16:   val = 32'd14668;
      5'd17:   val = 32'd7334;
      5'd18:   val = 32'd3667;
      5'd19:   val = 32'd1833;
      5'd20:   val = 32'd917;
      5'd21:   val = 32'd458;
      5'd22:   val = 32'd229;
      5'd23:   val = 32'd115;
      5'd24:   val = 32'd57;
      5'd25:   val = 32'd29;
      5'd26:   val = 32'd14;
      5'd27:   val = 32'd7;
      5'd28:   val = 32'd4;
      5'd29:   val = 32'd2;
      5'd30:   val = 32'd1;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

### rtl/core/vector_angle_degrees.sv
// ============================================================================
// vector_angle_degrees: angle of a two's complement vector in degrees
// Pipelined CORDIC arctangent with quadrant resolution, one vector per cycle.
// ============================================================================
//
// Give it a vector (x_coord, y_coord) and it returns the angle from the
// positive x axis in [0, 360) degrees, unsigned with FRAC_BITS fraction bits
// (1/128 degree at the default). The zero vector returns angle 0 with
// undefined_flag set. The core never stalls: busy stays low, so a beat is
// taken on every cycle that start is high. Each result comes out in order,
// marked by done_o for a single cycle; there is no way to hold results off,
// so the receiver must take every beat in the cycle it appears. Throughput is
// one vector per clock: one input register, one cell per CORDIC iteration,
// and one register for clamp, rounding and quadrant resolve.
//
module vector_angle_degrees (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  vad_pkg::vad_in_t    item_i,
  output logic                done_o,
  output vad_pkg::vad_out_t   result_o
);

  localparam int N = vad_pkg::CORDIC_STAGES;

  logic                                   accept;
  logic signed [vad_pkg::COORD_WIDTH-1:0] x_s, y_s;
  logic        [vad_pkg::COORD_WIDTH-1:0] x_mag, y_mag;
  vad_pkg::vad_ctl_t                      ctl_d, ctl_q;
  vad_pkg::vad_cord_t                     cord_d, cord_q;

  vad_pkg::vad_ctl_t  ctl_chain  [N+1];
  vad_pkg::vad_cord_t cord_chain [N+1];

  // Never back-pressure: every cell advances every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Take the low bits of each coordinate and fold into the first quadrant
  always_comb begin
    x_s   = item_i.x_coord[vad_pkg::COORD_WIDTH-1:0];
    y_s   = item_i.y_coord[vad_pkg::COORD_WIDTH-1:0];
    // negation in the unsigned domain keeps the most negative value exact
    x_mag = x_s[vad_pkg::COORD_WIDTH-1] ? (~x_s + 1'b1) : x_s;
    y_mag = y_s[vad_pkg::COORD_WIDTH-1] ? (~y_s + 1'b1) : y_s;

    ctl_d.valid  = accept;
    ctl_d.x_neg  = x_s[vad_pkg::COORD_WIDTH-1];
    ctl_d.x_zero = (x_s == '0);
    ctl_d.y_neg  = y_s[vad_pkg::COORD_WIDTH-1];
    ctl_d.y_zero = (y_s == '0);

    // pre-scale magnitudes so the shifts keep enough fraction bits
    cord_d.cx = {{(vad_pkg::DATA_W - vad_pkg::COORD_WIDTH - vad_pkg::PRESCALE){1'b0}},
                 x_mag, {vad_pkg::PRESCALE{1'b0}}};
    cord_d.cy = {{(vad_pkg::DATA_W - vad_pkg::COORD_WIDTH - vad_pkg::PRESCALE){1'b0}},
                 y_mag, {vad_pkg::PRESCALE{1'b0}}};
    cord_d.z  = '0;
  end

  // Input register: hold the folded beat for the first cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cord_q <= cord_d;
  end

  assign ctl_chain[0]  = ctl_q;
  assign cord_chain[0] = cord_q;

  // One cell per iteration; each hands its result to the next every cycle
  for (genvar g = 0; g < N; g++) begin : g_cell
    vad_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (vad_pkg::STAGE_W'(g)),
      .ctl_i   (ctl_chain[g]),
      .cord_i  (cord_chain[g]),
      .ctl_o   (ctl_chain[g+1]),
      .cord_o  (cord_chain[g+1])
    );
  end

  // Clamp, round, resolve quadrant and register the result beat
  vad_quad u_quad (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl_chain[N]),
    .z_i      (cord_chain[N].z),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

### rtl/core/vad_cell.sv
// ============================================================================
// vad_cell: one CORDIC vectoring iteration
// Rotates the vector toward the x axis by atan(2^-i) and registers the
// working set and the quadrant tag for the next cell.
// ============================================================================
module vad_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [vad_pkg::STAGE_W-1:0]   stage_i,
  input  vad_pkg::vad_ctl_t             ctl_i,
  input  vad_pkg::vad_cord_t            cord_i,
  output vad_pkg::vad_ctl_t             ctl_o,
  output vad_pkg::vad_cord_t            cord_o
);

  logic signed [vad_pkg::DATA_W-1:0] cx, cy, dx, dy;
  logic signed [vad_pkg::Z_W-1:0]    z, step;
  vad_pkg::vad_cord_t                cord_d, cord_q;
  vad_pkg::vad_ctl_t                 ctl_q;

  always_comb begin
    cx   = cord_i.cx;
    cy   = cord_i.cy;
    z    = cord_i.z;
    // arithmetic shift rounds toward minus infinity
    dx   = cy >>> stage_i;
    dy   = cx >>> stage_i;
    step = vad_pkg::atan_entry(vad_pkg::TAB_IDX_W'(stage_i));
    if (cy > 0) begin
      cord_d.cx = cx + dx;
      cord_d.cy = cy - dy;
      cord_d.z  = z + step;
    end else begin
      cord_d.cx = cx - dx;
      cord_d.cy = cy + dy;
      cord_d.z  = z - step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cord_q <= cord_d;
  end

  assign ctl_o  = ctl_q;
  assign cord_o = cord_q;

endmodule

### rtl/core/vad_quad.sv
// ============================================================================
// vad_quad: clamp, round and quadrant resolve
// Turns the first quadrant accumulator into the final angle in [0, 360)
// and registers the result beat with its strobe.
// ============================================================================
module vad_quad (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  vad_pkg::vad_ctl_t       ctl_i,
  input  logic signed [vad_pkg::Z_W-1:0] z_i,
  output logic                    done_o,
  output vad_pkg::vad_out_t       result_o
);

  logic [vad_pkg::Z_W-1:0]   z_clamp, z_round;
  logic [vad_pkg::A_W-1:0]   ang_a;
  logic [vad_pkg::RES_W-1:0] res;
  vad_pkg::vad_out_t         result_d, result_q;
  logic                      done_q;

  always_comb begin
    // clamp to [0, 90 deg], then round half up
    if (z_i < 0) begin
      z_clamp = '0;
    end else if (vad_pkg::Z_W'(z_i) > vad_pkg::Z_MAX) begin
      z_clamp = vad_pkg::Z_MAX;
    end else begin
      z_clamp = vad_pkg::Z_W'(z_i);
    end
    z_round = (z_clamp + vad_pkg::Z_ROUND) >> vad_pkg::ANG_SHIFT;
    // vector on the x axis takes no rotation at all
    ang_a   = ctl_i.y_zero ? '0 : z_round[vad_pkg::A_W-1:0];

    result_d.undefined_flag = 1'b0;
    if (ctl_i.x_zero) begin
      if (ctl_i.y_zero) begin
        res = '0;
        result_d.undefined_flag = 1'b1;
      end else if (ctl_i.y_neg) begin
        res = vad_pkg::TQTR_TURN;
      end else begin
        res = vad_pkg::QTR_TURN;
      end
    end else if (!ctl_i.x_neg) begin
      if (ctl_i.y_neg) begin
        // full turn minus zero wraps back to zero
        res = (ang_a == '0) ? '0 : vad_pkg::FULL_TURN - vad_pkg::RES_W'(ang_a);
      end else begin
        res = vad_pkg::RES_W'(ang_a);
      end
    end else begin
      if (ctl_i.y_zero) begin
        res = vad_pkg::HALF_TURN;
      end else if (ctl_i.y_neg) begin
        res = vad_pkg::HALF_TURN + vad_pkg::RES_W'(ang_a);
      end else begin
        res = vad_pkg::HALF_TURN - vad_pkg::RES_W'(ang_a);
      end
    end
    result_d.angle_deg = vad_pkg::ANGLE_W'(res);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

### dv/tb_vector_angle_degrees.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_vector_angle_degrees: self-checking bench for the CORDIC angle core
// Walks a directed sweep of axes, diagonals and extreme vectors, then a long
// random mix, with random gaps on the command side. Every result beat is
// compared field by field against a typed-in beat or an in-bench fixed-point CORDIC predictor.
// ============================================================================
module tb_vector_angle_degrees;
  import vad_pkg::*;

  localparam int  CLK_HALF       = 10;
  localparam int  LATENCY        = CORDIC_STAGES + 2;
  localparam int  DRAIN_CYCLES   = LATENCY + 8;
  localparam int  RANDOM_VECTORS = 650;
  localparam int  WATCHDOG_LIMIT = 4000;
  localparam int  ATAN_LEN       = 32;
  localparam int  MAX_REPORTED   = 10;

  localparam logic [ANGLE_W-1:0] DEG_0   = ANGLE_W'(0);
  localparam logic [ANGLE_W-1:0] DEG_90  = ANGLE_W'(90 << FRAC_BITS);
  localparam logic [ANGLE_W-1:0] DEG_180 = ANGLE_W'(180 << FRAC_BITS);
  localparam logic [ANGLE_W-1:0] DEG_270 = ANGLE_W'(270 << FRAC_BITS);

  localparam logic signed [FIELD_W-1:0] C_MAX = 16'sh7fff;
  localparam logic signed [FIELD_W-1:0] C_MIN = 16'sh8000;
  localparam logic signed [FIELD_W-1:0] C_P1  = 16'sd1;
  localparam logic signed [FIELD_W-1:0] C_M1  = -16'sd1;
  localparam logic signed [FIELD_W-1:0] C_0   = 16'sd0;

  // One row of the directed sweep; the expected beat is typed in only where
  // it is obvious (zero vector and the four half-axes).
  typedef struct {
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    bit                        known;
    logic [ANGLE_W-1:0]        angle;
    logic                      undef;
  } sweep_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  vad_in_t           item_i;
  logic              done_o;
  vad_out_t          result_o;

  // atan(2^-i) in degrees, scaled by 2^24, rounded to nearest
  longint atan_q24 [0:ATAN_LEN-1] = '{
    754974720, 445687602, 235489088, 119537938,
    60000934, 30029717, 15018523, 7509720,
    3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335,
    14668, 7334, 3667, 1833,
    917, 458, 229, 115,
    57, 29, 14, 7,
    4, 2, 1, 0
  };

  sweep_row_t sweep_rows [0:23] = '{
    '{C_0,   C_0,   1, DEG_0,   1'b1},   // zero vector
    '{C_P1,  C_0,   1, DEG_0,   1'b0},   // positive x axis
    '{C_MAX, C_0,   1, DEG_0,   1'b0},
    '{C_M1,  C_0,   1, DEG_180, 1'b0},   // negative x axis
    '{C_MIN, C_0,   1, DEG_180, 1'b0},
    '{C_0,   C_P1,  1, DEG_90,  1'b0},   // positive y axis
    '{C_0,   C_MAX, 1, DEG_90,  1'b0},
    '{C_0,   C_M1,  1, DEG_270, 1'b0},   // negative y axis
    '{C_0,   C_MIN, 1, DEG_270, 1'b0},
    '{C_P1,  C_P1,  0, DEG_0,   1'b0},   // diagonals, all four quadrants
    '{C_MAX, C_MAX, 0, DEG_0,   1'b0},
    '{C_MIN, C_MIN, 0, DEG_0,   1'b0},
    '{C_MAX, C_MIN, 0, DEG_0,   1'b0},
    '{C_MIN, C_MAX, 0, DEG_0,   1'b0},
    '{C_P1,  C_M1,  0, DEG_0,   1'b0},
    '{C_M1,  C_P1,  0, DEG_0,   1'b0},
    '{C_M1,  C_M1,  0, DEG_0,   1'b0},
    '{C_MAX, C_M1,  0, DEG_0,   1'b0},   // just below the axis: wraps past 360
    '{C_MIN, C_P1,  0, DEG_0,   1'b0},
    '{C_MIN, C_M1,  0, DEG_0,   1'b0},
    '{C_P1,  C_MAX, 0, DEG_0,   1'b0},
    '{C_P1,  C_MIN, 0, DEG_0,   1'b0},
    '{C_M1,  C_MIN, 0, DEG_0,   1'b0},
    '{16'sd12345, -16'sd6789, 0, DEG_0, 1'b0}
  };

  vad_out_t pending_angles [$];
  int       mismatch_count;
  int       vectors_sent;
  int       zero_vectors;
  int       axis_vectors;
  int       results_seen;
  int       burst_left;
  int       idle_cycles;

  vector_angle_degrees dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  initial clk_i = 1'b0;
  always #CLK_HALF clk_i = ~clk_i;

  // Sign-extend the used low bits of a coordinate field
  function automatic longint sext_coord(logic [FIELD_W-1:0] f);
    return longint'($signed(f[COORD_WIDTH-1:0]));
  endfunction

  // Fixed-point CORDIC vectoring on (|x|, |y|), then quadrant resolve
  function automatic vad_out_t predict_angle(vad_in_t v);
    longint   x, y, cx, cy, z, dx, dy, a, res, full;
    vad_out_t r;
    x    = sext_coord(v.x_coord);
    y    = sext_coord(v.y_coord);
    full = longint'(360) << FRAC_BITS;
    r    = '0;
    res  = 0;
    a    = 0;
    if (x == 0) begin
      if (y > 0) res = longint'(90) << FRAC_BITS;
      else if (y < 0) res = longint'(270) << FRAC_BITS;
      else r.undefined_flag = 1'b1;
    end else begin
      // on the x axis the first-quadrant angle is exactly zero
      if (y != 0) begin
        cx = (x < 0 ? -x : x) << PRESCALE;
        cy = (y < 0 ? -y : y) << PRESCALE;
        z  = 0;
        for (int i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
          dx = cy >>> i;
          dy = cx >>> i;
          if (cy > 0) begin
            cx += dx;
            cy -= dy;
            z  += atan_q24[i];
          end else begin
            cx -= dx;
            cy += dy;
            z  -= atan_q24[i];
          end
        end
        if (z < 0) z = 0;
        if (z > (longint'(90) << ANG_BITS)) z = longint'(90) << ANG_BITS;
        a = (z + (longint'(1) << (ANG_BITS - FRAC_BITS - 1))) >>> (ANG_BITS - FRAC_BITS);
      end
      if (x > 0) begin
        res = (y >= 0) ? a : full - a;
        if (res >= full) res -= full;
      end else if (y > 0) begin
        res = (longint'(180) << FRAC_BITS) - a;
      end else if (y < 0) begin
        res = (longint'(180) << FRAC_BITS) + a;
      end else begin
        res = longint'(180) << FRAC_BITS;
      end
    end
    r.angle_deg = ANGLE_W'(res);
    return r;
  endfunction

  function automatic logic signed [FIELD_W-1:0] edge_value();
    case ($urandom_range(0, 6))
      0:       return C_MIN;
      1:       return C_MIN + 16'sd1;
      2:       return C_M1;
      3:       return C_0;
      4:       return C_P1;
      5:       return C_MAX - 16'sd1;
      default: return C_MAX;
    endcase
  endfunction

  // Random vector drawn from a mix of shapes that stress different corners
  function automatic vad_in_t random_vector();
    int      kind;
    int      base;
    vad_in_t v;
    kind = $urandom_range(0, 99);
    v.x_coord = FIELD_W'($urandom);
    v.y_coord = FIELD_W'($urandom);
    if (kind < 45) begin
      // full-range random, already set
    end else if (kind < 60) begin
      // tiny magnitudes: coarse CORDIC inputs
      v.x_coord = FIELD_W'($urandom_range(0, 16) - 8);
      v.y_coord = FIELD_W'($urandom_range(0, 16) - 8);
    end else if (kind < 70) begin
      // on an axis, now and then the zero vector
      case ($urandom_range(0, 4))
        0:       v.x_coord = C_0;
        1:       v.y_coord = C_0;
        2: begin
          v.x_coord = C_0;
          v.y_coord = C_0;
        end
        default: if ($urandom_range(0, 1)) v.x_coord = C_0; else v.y_coord = C_0;
      endcase
    end else if (kind < 80) begin
      // near a diagonal
      base      = int'(v.x_coord);
      v.y_coord = FIELD_W'(($urandom_range(0, 1) ? base : -base)
                           + $urandom_range(0, 6) - 3);
    end else if (kind < 90) begin
      v.x_coord = edge_value();
      v.y_coord = edge_value();
    end else begin
      // one coordinate huge, the other tiny: angles close to an axis
      if ($urandom_range(0, 1)) begin
        v.x_coord = edge_value();
        v.y_coord = FIELD_W'($urandom_range(0, 4) - 2);
      end else begin
        v.y_coord = edge_value();
        v.x_coord = FIELD_W'($urandom_range(0, 4) - 2);
      end
    end
    return v;
  endfunction

  task automatic note_error(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTED) $display("%0t: mismatch: %s", $realtime, what);
  endtask

  // Present one vector and hold it until the core takes the beat
  task automatic issue_vector(input vad_in_t v, input bit known, input vad_out_t typed);
    start  <= 1'b1;
    item_i <= v;
    do @(posedge clk_i); while (busy === 1'b1);
    pending_angles.push_back(known ? typed : predict_angle(v));
    vectors_sent++;
    if (v.x_coord == 0 && v.y_coord == 0) zero_vectors++;
    else if (v.x_coord == 0 || v.y_coord == 0) axis_vectors++;
  endtask

  // Random gap on the command side: mostly none or short, a few long,
  // with occasional back-to-back bursts
  task automatic pause_sender();
    int pick;
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 99) < 3) burst_left = $urandom_range(20, 50);
      pick = $urandom_range(0, 99);
      if (pick < 55) gap = 0;
      else if (pick < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop start and hold until every outstanding result has come back
  task automatic drain_expected();
    if (pending_angles.size() != 0) begin
      start <= 1'b0;
      while (pending_angles.size() != 0) @(posedge clk_i);
    end
  endtask

  // Result checker: every done_o beat must match the oldest expectation
  always @(posedge clk_i) begin
    vad_out_t want;
    if (rst_ni && done_o === 1'b1) begin
      results_seen++;
      if (pending_angles.size() == 0) begin
        note_error($sformatf("unexpected result angle=%0d undef=%b",
                             result_o.angle_deg, result_o.undefined_flag));
      end else begin
        want = pending_angles.pop_front();
        if (result_o.angle_deg !== want.angle_deg)
          note_error($sformatf("angle_deg expected %0d got %0d",
                               want.angle_deg, result_o.angle_deg));
        if (result_o.undefined_flag !== want.undefined_flag)
          note_error($sformatf("undefined_flag expected %b got %b",
                               want.undefined_flag, result_o.undefined_flag));
      end
    end
  end

  // Watchdog: count cycles in which no beat moves in either direction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o === 1'b1) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", pending_angles.size());
        $display("tb_vector_angle_degrees: FAIL");
        $finish;
      end
    end
  end

  initial begin
    mismatch_count = 0;
    vectors_sent   = 0;
    zero_vectors   = 0;
    axis_vectors   = 0;
    results_seen   = 0;
    burst_left     = 0;
    idle_cycles    = 0;
    rst_ni         = 1'b0;
    start          = 1'b0;
    item_i         = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sweep
    foreach (sweep_rows[k]) begin
      issue_vector('{x_coord: sweep_rows[k].x, y_coord: sweep_rows[k].y},
                   sweep_rows[k].known,
                   '{angle_deg: sweep_rows[k].angle, undefined_flag: sweep_rows[k].undef});
      pause_sender();
    end
    drain_expected();

    // Random mix; stop halfway once to let the pipeline empty out
    for (int k = 0; k < RANDOM_VECTORS; k++) begin
      if (k == RANDOM_VECTORS / 2) drain_expected();
      issue_vector(random_vector(), 1'b0, '0);
      pause_sender();
    end

    drain_expected();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d vectors: %0d zero vectors, %0d on an axis, rest off-axis",
             vectors_sent, zero_vectors, axis_vectors);
    $display("checked %0d result beats, %0d mismatches, %0d still outstanding",
             results_seen, mismatch_count, pending_angles.size());
    if (mismatch_count == 0 && pending_angles.size() == 0) begin
      $display("tb_vector_angle_degrees: PASS");
    end else begin
      $display("tb_vector_angle_degrees: FAIL");
    end
    $finish;
  end

endmodule
